@@ hdl/merd_pkg.sv @@
// Shared widths and limits for the mean Euclidean row distance core.
// No dependencies; used by every module in hdl/.
package merd_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned SQ_W     = 2 * SAMPLE_W;
  localparam int unsigned ROOT_W   = 34;
  localparam int unsigned RAD_W    = 2 * ROOT_W;
  localparam int unsigned TOTAL_W  = 50;
  localparam int unsigned MEAN_W   = 34;
  localparam int unsigned ROWS_W   = 17;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

@@ hdl/merd_lane.sv @@
// One channel lane: absolute difference of two signed samples and its square.
// Depends on merd_pkg.
module merd_lane (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [merd_pkg::SAMPLE_W-1:0]  a_i,
  input  logic signed [merd_pkg::SAMPLE_W-1:0]  b_i,
  output logic        [merd_pkg::SQ_W-1:0]      sq_o
);

  logic [merd_pkg::SAMPLE_W:0]   diff;
  logic [merd_pkg::SAMPLE_W-1:0] mag;
  logic [merd_pkg::SQ_W-1:0]     sq_q;

  always_comb begin
    if (a_i >= b_i) begin
      diff = {a_i[merd_pkg::SAMPLE_W-1], a_i} - {b_i[merd_pkg::SAMPLE_W-1], b_i};
    end else begin
      diff = {b_i[merd_pkg::SAMPLE_W-1], b_i} - {a_i[merd_pkg::SAMPLE_W-1], a_i};
    end
    // The magnitude always fits in 32 unsigned bits.
    mag = diff[merd_pkg::SAMPLE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= mag * mag;
    end
  end

  assign sq_o = sq_q;

endmodule

@@ hdl/merd_sqrt.sv @@
// Digit-by-digit floor square root, one root bit per cycle.
// Depends on merd_pkg.
module merd_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [merd_pkg::RAD_W-1:0]    rad_i,
  output logic                          done_o,
  output logic [merd_pkg::ROOT_W-1:0]   root_o
);

  localparam int unsigned REM_W = merd_pkg::ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(merd_pkg::ROOT_W);

  logic [REM_W-1:0]             rem_q, rem_sh, trial;
  logic [merd_pkg::ROOT_W-1:0]  root_q;
  logic [merd_pkg::RAD_W-1:0]   rad_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         busy_q, done_q;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[merd_pkg::RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(merd_pkg::ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      root_q <= '0;
      rad_q  <= rad_i;
    end else if (busy_q) begin
      rad_q <= {rad_q[merd_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[merd_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[merd_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ hdl/merd_div.sv @@
// Restoring divider for the final mean, one quotient bit per cycle.
// Depends on merd_pkg.
module merd_div #(
  parameter int unsigned CW = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [merd_pkg::TOTAL_W-1:0]  num_i,
  input  logic [CW-1:0]                 den_i,
  output logic                          done_o,
  output logic [merd_pkg::MEAN_W-1:0]   quot_o
);

  localparam int unsigned CNT_W = $clog2(merd_pkg::TOTAL_W);

  logic [merd_pkg::TOTAL_W-1:0] num_q;
  logic [CW-1:0]                den_q;
  logic [CW:0]                  rem_q, rem_sh;
  logic [CNT_W-1:0]             cnt_q;
  logic                         busy_q, done_q;

  assign rem_sh = {rem_q[CW-1:0], num_q[merd_pkg::TOTAL_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(merd_pkg::TOTAL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The quotient bits shift into the numerator register as it empties.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        num_q <= {num_q[merd_pkg::TOTAL_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[merd_pkg::TOTAL_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  // A zero row count yields a zero mean.
  assign quot_o = (den_q == '0) ? '0 : num_q[merd_pkg::MEAN_W-1:0];

endmodule

@@ hdl/mean_euclidean_row_distance_core.sv @@
// Top level of the mean Euclidean row distance core: lanes, merge, control.
// Depends on merd_pkg, merd_lane, merd_sqrt and merd_div.
//
//  Channel  Direction  Handshake             Payload
//  s_axis   in         tvalid/tready         tdata: A ch0..ch(N-1), B ch0..ch(N-1); tlast: last_row
//  m_axis   out        tvalid/tready         tdata: mean_distance, rows_counted; tuser: count_saturated
//
// A row passes through these steps: the accepting cycle registers the lane squares,
// the merge state sums them into the bit-serial square root, and the root is then
// accumulated. A last row then runs the serial divider, sees it finish and
// registers the result.
// Reset clears the running total, row count and flag. A stalled output holds its
// transaction while the next row is taken; a finished mean waits for the slot.
module mean_euclidean_row_distance_core #(
  parameter int unsigned MAX_ROWS = 65536,
  parameter int unsigned CHANNELS = 4
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // rec_a_ch0 .. rec_a_ch(N-1), rec_b_ch0 .. rec_b_ch(N-1), 32 bits each
  input  logic [2*CHANNELS*merd_pkg::SAMPLE_W-1:0] s_axis_tdata,
  input  logic                                    s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // mean_distance [33:0], rows_counted [50:34], zero [55:51]
  output logic [55:0]                             m_axis_tdata,
  // count_saturated
  output logic                                    m_axis_tuser
);

  localparam int unsigned CW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned SUM_W = merd_pkg::SQ_W + $clog2(CHANNELS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MERGE = 3'd1;
  localparam logic [2:0] S_ROOT  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_HOLD  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept, last_q;

  logic [merd_pkg::SQ_W-1:0] sq [CHANNELS];
  logic [SUM_W-1:0]          sum;

  logic                        root_done;
  logic [merd_pkg::ROOT_W-1:0] root;

  logic [merd_pkg::TOTAL_W-1:0] total_q, total_d;
  logic [merd_pkg::TOTAL_W:0]   total_add;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         sat_q, sat_d;
  logic                         full;
  logic [merd_pkg::TOTAL_W-1:0] acc_total;
  logic [CW-1:0]                acc_cnt;
  logic                         acc_sat;

  logic                         div_start, div_done;
  logic [merd_pkg::MEAN_W-1:0]  quot;
  logic [CW-1:0]                res_cnt_q;
  logic                         res_sat_q;

  logic                         out_vld_q, out_vld_d, out_load;
  logic [merd_pkg::MEAN_W-1:0]  out_mean_q;
  logic [merd_pkg::ROWS_W-1:0]  out_rows_q;
  logic                         out_sat_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    merd_lane u_lane (
      .clk_i (clk_i),
      .en_i  (accept),
      .a_i   (s_axis_tdata[k*merd_pkg::SAMPLE_W +: merd_pkg::SAMPLE_W]),
      .b_i   (s_axis_tdata[(CHANNELS+k)*merd_pkg::SAMPLE_W +: merd_pkg::SAMPLE_W]),
      .sq_o  (sq[k])
    );
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      sum = sum + SUM_W'(sq[k]);
    end
  end

  merd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_MERGE),
    .rad_i   (merd_pkg::RAD_W'(sum)),
    .done_o  (root_done),
    .root_o  (root)
  );

  // Accumulate the new distance unless the row count is already full.
  always_comb begin
    full      = (cnt_q >= CW'(MAX_ROWS));
    total_add = {1'b0, total_q} + (merd_pkg::TOTAL_W + 1)'(root);
    if (full) begin
      acc_total = total_q;
      acc_cnt   = cnt_q;
      acc_sat   = 1'b1;
    end else begin
      acc_total = (total_add > {1'b0, merd_pkg::TOTAL_MAX}) ?
                  merd_pkg::TOTAL_MAX : total_add[merd_pkg::TOTAL_W-1:0];
      acc_cnt   = cnt_q + 1'b1;
      acc_sat   = sat_q;
    end
  end

  assign div_start = (state_q == S_ROOT) && root_done && last_q;

  merd_div #(.CW(CW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_total),
    .den_i   (acc_cnt),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign out_load = (state_q == S_HOLD) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    cnt_d   = cnt_q;
    sat_d   = sat_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_MERGE;
      end
      S_MERGE: begin
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) begin
          if (last_q) begin
            total_d = '0;
            cnt_d   = '0;
            sat_d   = 1'b0;
            state_d = S_DIV;
          end else begin
            total_d = acc_total;
            cnt_d   = acc_cnt;
            sat_d   = acc_sat;
            state_d = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (div_done) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (m_axis_tvalid && m_axis_tready) out_vld_d = 1'b0;
    if (out_load) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      cnt_q     <= '0;
      sat_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      cnt_q     <= cnt_d;
      sat_q     <= sat_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= s_axis_tlast;
    end
    if (div_start) begin
      res_cnt_q <= acc_cnt;
      res_sat_q <= acc_sat;
    end
    if (out_load) begin
      out_mean_q <= quot;
      out_rows_q <= merd_pkg::ROWS_W'(res_cnt_q);
      out_sat_q  <= res_sat_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_rows_q, out_mean_q};
  assign m_axis_tuser  = out_sat_q;

endmodule

@@ dv/merd_checker.sv @@
// Checker for the mean Euclidean row distance core: predicts each mean from
// accepted rows and compares it with the output transactions. Uses merd_pkg.
`timescale 1ns / 100ps

module merd_checker #(
  parameter int unsigned MAX_ROWS = 65536,
  parameter int unsigned CHANNELS = 4
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  input  logic                                     s_axis_tready,
  input  logic [2*CHANNELS*merd_pkg::SAMPLE_W-1:0] s_axis_tdata,
  input  logic                                     s_axis_tlast,
  input  logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  input  logic [55:0]                              m_axis_tdata,
  input  logic                                     m_axis_tuser,
  output int                                       fail_count_o,
  output int                                       pending_o
);

  typedef struct packed {
    logic [merd_pkg::MEAN_W-1:0] mean;
    logic [merd_pkg::ROWS_W-1:0] rows;
    logic                        sat;
  } mean_result_t;

  mean_result_t    means_due[$];
  logic [63:0]     total_acc;
  logic [31:0]     rows_acc;
  logic            sat_acc;

  // Floor square root of a value below 2^68, one result bit at a time.
  function automatic logic [merd_pkg::ROOT_W-1:0] floor_root(
    input logic [merd_pkg::RAD_W-1:0] radicand
  );
    logic [merd_pkg::ROOT_W-1:0] root;
    logic [merd_pkg::ROOT_W-1:0] trial;
    root = '0;
    for (int b = merd_pkg::ROOT_W - 1; b >= 0; b--) begin
      trial = root | (34'd1 << b);
      if ({34'd0, trial} * {34'd0, trial} <= radicand) root = trial;
    end
    return root;
  endfunction

  function automatic logic [merd_pkg::ROOT_W-1:0] row_distance(
    input logic [2*CHANNELS*32-1:0] row
  );
    logic [merd_pkg::RAD_W-1:0] radicand;
    logic signed [32:0] diff;
    logic [32:0] mag;
    radicand = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      diff = $signed(row[k*32 +: 32]) - $signed(row[(CHANNELS+k)*32 +: 32]);
      mag = diff[32] ? -diff : diff;
      radicand += {35'd0, mag} * {35'd0, mag};
    end
    return floor_root(radicand);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mean_result_t got;
    mean_result_t want;
    if (!rst_ni) begin
      total_acc <= '0;
      rows_acc <= '0;
      sat_acc <= 1'b0;
      fail_count_o <= 0;
      pending_o <= 0;
      means_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        logic [63:0] t;
        logic [31:0] r;
        logic        s;
        t = total_acc;
        r = rows_acc;
        s = sat_acc;
        if (r >= MAX_ROWS) begin
          s = 1'b1;
        end else begin
          t += row_distance(s_axis_tdata);
          if (t > merd_pkg::TOTAL_MAX) t = merd_pkg::TOTAL_MAX;
          r++;
        end
        if (s_axis_tlast) begin
          want.mean = (r != 0) ? merd_pkg::MEAN_W'(t / r) : '0;
          want.rows = r[merd_pkg::ROWS_W-1:0];
          want.sat = s;
          means_due.insert(means_due.size(), want);
          t = '0;
          r = '0;
          s = 1'b0;
        end
        total_acc <= t;
        rows_acc <= r;
        sat_acc <= s;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.mean = m_axis_tdata[33:0];
        got.rows = m_axis_tdata[50:34];
        got.sat = m_axis_tuser;
        if (means_due.size() == 0) begin
          $display("%0t: expected no result, actual %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = means_due.pop_front();
          if (got !== want || m_axis_tdata[55:51] !== 5'd0) begin
            $display("%0t: mismatch expected mean %h rows %0d sat %b,",
                     $time, want.mean, want.rows, want.sat);
            $display("%0t:          actual mean %h rows %0d sat %b pad %h",
                     $time, got.mean, got.rows, got.sat, m_axis_tdata[55:51]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= means_due.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for mean_euclidean_row_distance_core: drives rows in bursts,
// stalls the output, and reports the verdict. Depends on merd_checker, merd_pkg.
`timescale 1ns / 100ps

module tb;
  localparam int unsigned CH = 4;
  localparam int unsigned MAXR = 65536;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [2*CH*32-1:0] s_axis_tdata = '0;
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [55:0]        m_axis_tdata;
  logic               m_axis_tuser;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  bit                 long_hold = 1'b0;
  bit                 stall_free = 1'b0;

  always #6 clk_i = ~clk_i;

  mean_euclidean_row_distance_core #(.MAX_ROWS(MAXR), .CHANNELS(CH)) uut (.*);

  merd_checker #(.MAX_ROWS(MAXR), .CHANNELS(CH)) checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending));

  // Receiver stalls on its own pattern; a long hold-off backs up the core.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (long_hold) m_axis_tready <= 1'b0;
    else if (stall_free) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
    if (cycle_count > 3_000_000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // Sends one row and waits until it is taken; a random gap may follow.
  task automatic send_row(input logic [2*CH*32-1:0] row, input logic last, input bit gaps);
    s_axis_tdata <= row;
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  endtask

  task automatic send_frame(input int rows, input bit gaps);
    logic [2*CH*32-1:0] row;
    for (int i = 0; i < rows; i++) begin
      for (int k = 0; k < 2 * CH; k++) row[k*32 +: 32] = pick_sample();
      send_row(row, i == rows - 1, gaps);
    end
  endtask

  initial begin
    logic [2*CH*32-1:0] row;
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes: largest distance, zero distance, mixed signs.
    row = {{CH{32'h8000_0000}}, {CH{32'h7FFF_FFFF}}};
    send_row(row, 1'b1, 1'b0);
    send_row(~row, 1'b1, 1'b0);
    send_row('0, 1'b1, 1'b0);
    row = {{CH{32'hFFFF_FFFF}}, {CH{32'h0000_0001}}};
    send_row(row, 1'b0, 1'b0);
    send_row('1, 1'b0, 1'b0);
    send_row(row, 1'b1, 1'b0);
    send_frame(8, 1'b0);

    // Long hold-off while rows keep coming, so the input backs up.
    long_hold = 1'b1;
    fork
      begin
        send_frame(1, 1'b0);
        send_frame(6, 1'b0);
        send_frame(3, 1'b0);
        send_frame(2, 1'b0);
      end
      begin
        repeat (600) @(posedge clk_i);
        long_hold = 1'b0;
      end
    join

    // Random frames, mostly short; rows total at least 1120 and under 1180.
    n = 0;
    while (n < 1120) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      stall_free = ($urandom_range(0, 4) == 0);
      send_frame(len, $urandom_range(0, 2) != 0);
      n += len;
    end
    s_axis_tvalid <= 1'b0;

    stall_free = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/merd_pkg.sv
hdl/merd_lane.sv
hdl/merd_sqrt.sv
hdl/merd_div.sv
hdl/mean_euclidean_row_distance_core.sv
dv/merd_checker.sv
dv/tb.sv
